### hdl/htfd_pkg.sv
`default_nettype none

package htfd_pkg;

  localparam int unsigned NUM_VALUES = 11;

  localparam logic [5:0] LINE_LEN  = 6'd40;
  localparam logic [5:0] FIRST_HEX = 6'd7;
  localparam logic [5:0] TAG_LEN   = 6'd4;
  localparam logic [5:0] POS_MAX   = 6'd63;
  localparam logic [3:0] CSUM_IDX  = 4'd11;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_CSUM = 2'd2
  } status_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic [3:0] idx;
    logic       sgn;
    logic       wide;
  } fld_info_t;

  typedef struct packed {
    status_t            status;
    logic [3:0]         flight_state;
    logic signed [7:0]  accel_value;
    logic [15:0]        speed_value;
    logic [15:0]        height_value;
    logic [7:0]         pressure_value;
    logic signed [7:0]  temperature_value;
    logic signed [15:0] roll_value;
    logic signed [15:0] pitch_value;
    logic signed [15:0] yaw_value;
    logic signed [7:0]  latitude_value;
    logic signed [7:0]  longitude_value;
  } result_t;

  function automatic logic [7:0] tag_byte(input logic [1:0] p);
    logic [7:0] b;
    case (p)
      2'd0:    b = 8'h45;
      2'd1:    b = 8'h53;
      2'd2:    b = 8'h46;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  function automatic fld_info_t fld_lookup(input logic [5:0] p);
    fld_info_t  f;
    logic [5:0] start;
    logic [5:0] len;
    logic [3:0] idx;
    logic       sgn;
    case (p) inside
      [6'd0:6'd7]:   begin idx = 4'd0;  start = 6'd7;  len = 6'd1; sgn = 1'b0; end
      [6'd8:6'd9]:   begin idx = 4'd1;  start = 6'd8;  len = 6'd2; sgn = 1'b1; end
      [6'd10:6'd13]: begin idx = 4'd2;  start = 6'd10; len = 6'd4; sgn = 1'b0; end
      [6'd14:6'd17]: begin idx = 4'd3;  start = 6'd14; len = 6'd4; sgn = 1'b0; end
      [6'd18:6'd19]: begin idx = 4'd4;  start = 6'd18; len = 6'd2; sgn = 1'b0; end
      [6'd20:6'd21]: begin idx = 4'd5;  start = 6'd20; len = 6'd2; sgn = 1'b1; end
      [6'd22:6'd25]: begin idx = 4'd6;  start = 6'd22; len = 6'd4; sgn = 1'b1; end
      [6'd26:6'd29]: begin idx = 4'd7;  start = 6'd26; len = 6'd4; sgn = 1'b1; end
      [6'd30:6'd33]: begin idx = 4'd8;  start = 6'd30; len = 6'd4; sgn = 1'b1; end
      [6'd34:6'd35]: begin idx = 4'd9;  start = 6'd34; len = 6'd2; sgn = 1'b1; end
      [6'd36:6'd37]: begin idx = 4'd10; start = 6'd36; len = 6'd2; sgn = 1'b1; end
      default:       begin idx = CSUM_IDX; start = 6'd38; len = 6'd2; sgn = 1'b0; end
    endcase
    f.first = (p == start);
    f.last  = (p == start + len - 6'd1);
    f.idx   = idx;
    f.sgn   = sgn;
    f.wide  = (len == 6'd4);
    return f;
  endfunction

endpackage

`default_nettype wire

### hdl/htfd_if.sv
`default_nettype none

interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, kind, char_in, input ready);
  modport sink   (input valid, kind, char_in, output ready);
endinterface

interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         flight_state;
  logic signed [7:0]  accel_value;
  logic [15:0]        speed_value;
  logic [15:0]        height_value;
  logic [7:0]         pressure_value;
  logic signed [7:0]  temperature_value;
  logic signed [15:0] roll_value;
  logic signed [15:0] pitch_value;
  logic signed [15:0] yaw_value;
  logic signed [7:0]  latitude_value;
  logic signed [7:0]  longitude_value;

  modport source (output valid, status, flight_state, accel_value, speed_value, height_value,
                  pressure_value, temperature_value, roll_value, pitch_value, yaw_value,
                  latitude_value, longitude_value, input ready);
  modport sink   (input valid, status, flight_state, accel_value, speed_value, height_value,
                  pressure_value, temperature_value, roll_value, pitch_value, yaw_value,
                  latitude_value, longitude_value, output ready);
endinterface

`default_nettype wire

### hdl/hex_telemetry_frame_decoder_top.sv
`default_nettype none

// The decoder takes one character or end-of-line transaction in every cycle and checks the
// line as it arrives, so the work for each character is a single registered step. Each
// end of line gives one result transaction, held in a two-entry output buffer (output
// register plus skid stage); input ready falls only while both entries are full, so a
// stalled result does not stop the next characters from being taken.

module hex_telemetry_frame_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  htfd_in_if.sink     in_ch,
  htfd_out_if.source  out_ch
);

  logic              res_valid;
  htfd_pkg::result_t res;

  logic              out_valid_r, out_valid_nxt;
  htfd_pkg::result_t out_r,       out_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  htfd_pkg::result_t skid_r,      skid_nxt;
  logic              take;
  logic              pop;
  logic              out_free;

  assign in_ch.ready = !skid_valid_r;
  assign take        = in_ch.valid && in_ch.ready;

  htfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .kind      (in_ch.kind),
    .char_in   (in_ch.char_in),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    pop            = out_valid_r && out_ch.ready;
    out_free       = !out_valid_r || pop;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = res_valid;
        skid_nxt       = res;
      end else begin
        out_valid_nxt = res_valid;
        out_nxt       = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_r.status;
  assign out_ch.flight_state      = out_r.flight_state;
  assign out_ch.accel_value       = out_r.accel_value;
  assign out_ch.speed_value       = out_r.speed_value;
  assign out_ch.height_value      = out_r.height_value;
  assign out_ch.pressure_value    = out_r.pressure_value;
  assign out_ch.temperature_value = out_r.temperature_value;
  assign out_ch.roll_value        = out_r.roll_value;
  assign out_ch.pitch_value       = out_r.pitch_value;
  assign out_ch.yaw_value         = out_r.yaw_value;
  assign out_ch.latitude_value    = out_r.latitude_value;
  assign out_ch.longitude_value   = out_r.longitude_value;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("result produced while both buffer entries are full");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid_r)
    else $error("result transaction lost in output buffer");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == htfd_pkg::ST_BAD) |->
      (out_r.speed_value == 16'h0000 && out_r.roll_value == 16'sh0000 &&
       out_r.flight_state == 4'h0))
    else $error("bad frame result carries non-zero values");

endmodule

`default_nettype wire

### hdl/htfd_core.sv
`default_nettype none

module htfd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              kind,
  input  logic [7:0]        char_in,
  output logic              res_valid,
  output htfd_pkg::result_t res
);

  logic [5:0]         pos_r,  pos_nxt;
  logic               good_r, good_nxt;
  logic [15:0]        acc_r,  acc_nxt;
  logic               neg_r,  neg_nxt;
  logic signed [19:0] sum_r,  sum_nxt;
  logic [7:0]         chk_r,  chk_nxt;
  logic [15:0]        fields_r [htfd_pkg::NUM_VALUES];

  htfd_pkg::fld_info_t fi;
  logic               hex_ok;
  logic [3:0]         digit;
  logic               lead;
  logic [15:0]        acc_base;
  logic signed [19:0] bias;
  logic               fld_we;
  logic               bad;
  logic               match;

  always_comb begin
    fi     = htfd_pkg::fld_lookup(pos_r);
    hex_ok = 1'b1;
    digit  = 4'd0;
    if (char_in inside {[8'h30:8'h39]}) begin
      digit = char_in[3:0];
    end else if (char_in inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      digit = char_in[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    lead = char_in inside {8'h38, 8'h39, [8'h61:8'h66]};

    pos_nxt  = pos_r;
    good_nxt = good_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    sum_nxt  = sum_r;
    chk_nxt  = chk_r;
    fld_we   = 1'b0;
    acc_base = fi.first ? 16'h0000 : acc_r;
    bias     = 20'sd0;

    if (take) begin
      if (kind) begin
        pos_nxt  = 6'd0;
        good_nxt = 1'b1;
        acc_nxt  = 16'h0000;
        neg_nxt  = 1'b0;
        sum_nxt  = 20'sd0;
        chk_nxt  = 8'h00;
      end else begin
        if (pos_r < htfd_pkg::TAG_LEN) begin
          if (char_in != htfd_pkg::tag_byte(pos_r[1:0])) begin
            good_nxt = 1'b0;
          end
        end else if (pos_r >= htfd_pkg::FIRST_HEX && pos_r < htfd_pkg::LINE_LEN) begin
          if (!hex_ok) begin
            good_nxt = 1'b0;
          end
          if (fi.first) begin
            neg_nxt = lead;
          end
          acc_nxt = {acc_base[11:0], digit};
          if (fi.sgn && neg_nxt) begin
            bias = fi.wide ? 20'sh10000 : 20'sh00100;
          end
          if (fi.last) begin
            if (fi.idx != htfd_pkg::CSUM_IDX) begin
              fld_we  = 1'b1;
              sum_nxt = sum_r + $signed({4'b0000, acc_nxt}) - bias;
            end else begin
              chk_nxt = acc_nxt[7:0];
            end
          end
        end
        if (pos_r != htfd_pkg::POS_MAX) begin
          pos_nxt = pos_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 6'd0;
      good_r <= 1'b1;
      acc_r  <= 16'h0000;
      neg_r  <= 1'b0;
      sum_r  <= 20'sd0;
      chk_r  <= 8'h00;
    end else begin
      pos_r  <= pos_nxt;
      good_r <= good_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      sum_r  <= sum_nxt;
      chk_r  <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fld_we) begin
      fields_r[fi.idx] <= acc_nxt;
    end
  end

  // A negative sum leaves a negative remainder, which only matches when it is zero.
  always_comb begin
    bad   = !good_r || (pos_r != htfd_pkg::LINE_LEN);
    match = (sum_r[7:0] == chk_r) && (!sum_r[19] || (sum_r[7:0] == 8'h00));

    res_valid = take && kind;
    if (bad) begin
      res        = '0;
      res.status = htfd_pkg::ST_BAD;
    end else begin
      res.status            = match ? htfd_pkg::ST_OK : htfd_pkg::ST_CSUM;
      res.flight_state      = fields_r[0][3:0];
      res.accel_value       = fields_r[1][7:0];
      res.speed_value       = fields_r[2];
      res.height_value      = fields_r[3];
      res.pressure_value    = fields_r[4][7:0];
      res.temperature_value = fields_r[5][7:0];
      res.roll_value        = fields_r[6];
      res.pitch_value       = fields_r[7];
      res.yaw_value         = fields_r[8];
      res.latitude_value    = fields_r[9][7:0];
      res.longitude_value   = fields_r[10][7:0];
    end
  end

endmodule

`default_nettype wire
